>>> rtl/core/sbnh_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbnh_pkg
// Shared types and constants of the segment / box nearest-hit unit.
// ----------------------------------------------------------------------------
package sbnh_pkg;

    localparam int COORD_W    = 32;
    localparam int OFF_W      = COORD_W + 1;   // difference of two coordinates
    localparam int MFRAC_W    = 17;            // max_fraction and hit_fraction
    localparam int FRAC_W     = MFRAC_W + 2;   // signed fraction, [-2.0, 2.0]
    localparam int Q_SHIFT    = 16;
    localparam int DIV_STEPS  = 17;            // quotient bits below saturation
    localparam int QMAG_W     = DIV_STEPS + 1;
    localparam int DIV_W      = OFF_W + DIV_STEPS;
    localparam int STEP_W     = $clog2(DIV_STEPS + 1);
    localparam int ONE_Q16    = 65536;
    localparam int SAT_Q16    = 131072;

    localparam int MAX_BOXES  = 1024;
    localparam int BOX_IDX_W  = $clog2(MAX_BOXES);
    localparam int HIT_BOX_W  = 10;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = COORD_W;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_START_X  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_START_Y  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_START_Z  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_END_X    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_END_Y    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_END_Z    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_FRAC = 3'd6;

    // normal axis codes
    localparam logic [1:0] AXIS_X    = 2'd0;
    localparam logic [1:0] AXIS_Y    = 2'd1;
    localparam logic [1:0] AXIS_Z    = 2'd2;
    localparam logic [1:0] AXIS_NONE = 2'd3;

    typedef logic signed [COORD_W-1:0] t_coord;
    typedef logic signed [OFF_W-1:0]   t_off;
    typedef logic signed [FRAC_W-1:0]  t_frac;

    localparam t_frac FRAC_ONE = t_frac'(ONE_Q16);

    typedef struct packed {
        t_coord box_min_x;
        t_coord box_min_y;
        t_coord box_min_z;
        t_coord box_max_x;
        t_coord box_max_y;
        t_coord box_max_z;
        logic   last_box;
    } t_box;

    typedef struct packed {
        logic                 found;
        logic [HIT_BOX_W-1:0] hit_box;
        logic [MFRAC_W-1:0]   hit_fraction;
        logic [1:0]           normal_axis;
        logic                 normal_positive;
        logic                 start_solid;
        logic                 all_solid;
    } t_hit;

endpackage

>>> rtl/core/sbnh_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbnh_div
// Radix-2 restoring divider for one Q.16 slab fraction: (num << 16) / den,
// truncated toward zero and saturated to [-2.0, 2.0]. One bit per cycle.
// ----------------------------------------------------------------------------
module sbnh_div import sbnh_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_start,
    input  t_off  i_num,
    input  t_off  i_den,
    output logic  o_done,
    output t_frac o_quot
);

    logic              r_busy;
    logic              r_done;
    logic              r_neg;
    logic [STEP_W-1:0] r_step;
    logic [DIV_W-1:0]  r_rem;
    logic [DIV_W-1:0]  r_dsh;
    logic [QMAG_W-1:0] r_q;
    t_frac             r_quot;

    logic [OFF_W-1:0]  num_mag;
    logic [OFF_W-1:0]  den_mag;
    logic [DIV_W:0]    diff;
    logic              ge;
    logic [QMAG_W-1:0] n_q;
    logic [QMAG_W-1:0] fin_mag;
    t_frac             fin_pos;
    logic              fin;

    assign num_mag = i_num[OFF_W-1] ? OFF_W'(-i_num) : OFF_W'(i_num);
    assign den_mag = i_den[OFF_W-1] ? OFF_W'(-i_den) : OFF_W'(i_den);

    // one shared subtract and compare
    assign diff = {1'b0, r_rem} - {1'b0, r_dsh};
    assign ge   = ~diff[DIV_W];
    assign n_q  = {r_q[QMAG_W-2:0], ge};

    always_comb begin
        fin     = 1'b0;
        fin_mag = n_q;
        if (r_busy) begin
            if (r_step == STEP_W'(DIV_STEPS)) begin
                // first step checks the quotient against the saturation bound
                fin     = ge;
                fin_mag = QMAG_W'(SAT_Q16);
            end else begin
                fin     = (r_step == '0);
            end
        end
    end

    assign fin_pos = t_frac'({1'b0, fin_mag});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= fin;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (fin) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= DIV_W'({num_mag, {Q_SHIFT{1'b0}}});
            r_dsh  <= DIV_W'({den_mag, {DIV_STEPS{1'b0}}});
            r_neg  <= i_num[OFF_W-1] ^ i_den[OFF_W-1];
            r_step <= STEP_W'(DIV_STEPS);
            r_q    <= '0;
        end else if (r_busy) begin
            r_dsh  <= r_dsh >> 1;
            r_step <= r_step - 1'b1;
            if (r_step != STEP_W'(DIV_STEPS)) begin
                r_q <= n_q;
                if (ge) begin
                    r_rem <= diff[DIV_W-1:0];
                end
            end
        end
        if (fin) begin
            r_quot <= r_neg ? -fin_pos : fin_pos;
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

>>> rtl/core/segment_box_nearest_hit_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// segment_box_nearest_hit_unit
// Slab test of a fixed segment against a stream of boxes; nearest hit kept.
// ----------------------------------------------------------------------------
// One box is taken at a time. A box with a min above its max skips the slab
// work and goes straight to S_FINISH. Otherwise each axis with nonzero segment
// extent forms two fractions on the shared bit-serial divider, one after the
// other, so a box takes less time where an axis is parallel to the segment
// or a quotient saturates on its first step. The box marked last
// passes through S_EMIT to hand its result to the output register;
// the next box can be taken while that result waits on the output.
// Configuration must be written only while no box is in flight; the unit itself does not enforce this.
// ----------------------------------------------------------------------------
module segment_box_nearest_hit_unit import sbnh_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  t_box                  i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output t_hit                  o_out_data
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_AXIS   = 3'd1;
    localparam logic [2:0] S_LO     = 3'd2;
    localparam logic [2:0] S_HI     = 3'd3;
    localparam logic [2:0] S_FINISH = 3'd4;
    localparam logic [2:0] S_EMIT   = 3'd5;

    // configuration
    t_coord               r_start_x, r_start_y, r_start_z;
    t_coord               r_end_x, r_end_y, r_end_z;
    logic [MFRAC_W-1:0]   r_max_frac;

    // sequencer and per-box work
    logic [2:0]           r_state;
    logic [1:0]           r_axis;
    t_box                 r_box;
    logic                 r_box_ok;
    logic                 r_intersects;
    logic                 r_inside;
    t_frac                r_enter;
    t_frac                r_leave;
    t_frac                r_near;
    logic [1:0]           r_axis_sel;
    logic                 r_sign_sel;

    // trace state
    logic [BOX_IDX_W-1:0] r_box_cnt;
    logic [MFRAC_W-1:0]   r_best_frac;
    logic [BOX_IDX_W-1:0] r_best_box;
    logic [1:0]           r_best_axis;
    logic                 r_best_sign;
    logic                 r_best_start_solid;
    logic                 r_best_all_solid;
    logic                 r_any_found;

    logic                 r_out_valid;
    t_hit                 r_out;

    t_coord               ax_s, ax_e, ax_min, ax_max;
    t_off                 ax_d, off_lo, off_hi;
    logic                 ax_in;
    logic                 div_start;
    logic                 div_done;
    t_frac                div_quot;
    t_off                 div_num;
    logic                 in_accept;
    logic                 box_ok_in;
    t_frac                near_v, far_v;
    logic                 sg_v;
    logic                 hit;
    logic                 bound_ok;
    logic                 emit_go;
    logic                 last_axis;

    always_comb begin
        unique case (r_axis)
            AXIS_X: begin
                ax_s = r_start_x; ax_e = r_end_x;
                ax_min = r_box.box_min_x; ax_max = r_box.box_max_x;
            end
            AXIS_Y: begin
                ax_s = r_start_y; ax_e = r_end_y;
                ax_min = r_box.box_min_y; ax_max = r_box.box_max_y;
            end
            default: begin
                ax_s = r_start_z; ax_e = r_end_z;
                ax_min = r_box.box_min_z; ax_max = r_box.box_max_z;
            end
        endcase
    end

    assign ax_d   = {ax_e[COORD_W-1], ax_e} - {ax_s[COORD_W-1], ax_s};
    assign off_lo = {ax_min[COORD_W-1], ax_min} - {ax_s[COORD_W-1], ax_s};
    assign off_hi = {ax_max[COORD_W-1], ax_max} - {ax_s[COORD_W-1], ax_s};
    assign ax_in  = (ax_s >= ax_min) && (ax_s <= ax_max);

    assign div_start = ((r_state == S_AXIS) && r_box_ok && (ax_d != '0)) ||
                       ((r_state == S_LO) && div_done);
    assign div_num   = (r_state == S_AXIS) ? off_lo : off_hi;

    sbnh_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (ax_d),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    assign o_in_ready = (r_state == S_IDLE);
    assign in_accept  = i_in_valid && o_in_ready;
    assign box_ok_in  = (i_in_data.box_min_x <= i_in_data.box_max_x) &&
                        (i_in_data.box_min_y <= i_in_data.box_max_y) &&
                        (i_in_data.box_min_z <= i_in_data.box_max_z);

    // order the slab ends; a swap flips the normal to +1
    always_comb begin
        if (r_near > div_quot) begin
            near_v = div_quot;
            far_v  = r_near;
            sg_v   = 1'b1;
        end else begin
            near_v = r_near;
            far_v  = div_quot;
            sg_v   = 1'b0;
        end
    end

    assign last_axis = (r_axis == AXIS_Z);
    assign bound_ok  = (r_max_frac != '0) && (r_max_frac <= MFRAC_W'(ONE_Q16));
    assign hit = r_box_ok && r_intersects && (r_enter <= r_leave) && bound_ok &&
                 (r_enter < t_frac'({2'b00, r_max_frac})) &&
                 (!r_any_found || (r_enter < t_frac'({2'b00, r_best_frac})));
    assign emit_go = (r_state == S_EMIT) && (!r_out_valid || i_out_ready);

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_x  <= '0;
            r_start_y  <= '0;
            r_start_z  <= '0;
            r_end_x    <= '0;
            r_end_y    <= '0;
            r_end_z    <= '0;
            r_max_frac <= MFRAC_W'(ONE_Q16);
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_START_X:  r_start_x  <= i_cfg_data;
                CFG_START_Y:  r_start_y  <= i_cfg_data;
                CFG_START_Z:  r_start_z  <= i_cfg_data;
                CFG_END_X:    r_end_x    <= i_cfg_data;
                CFG_END_Y:    r_end_y    <= i_cfg_data;
                CFG_END_Z:    r_end_z    <= i_cfg_data;
                CFG_MAX_FRAC: r_max_frac <= i_cfg_data[MFRAC_W-1:0];
                default: ;
            endcase
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (in_accept) r_state <= S_AXIS;
                end
                S_AXIS: begin
                    if (!r_box_ok) begin
                        r_state <= S_FINISH;
                    end else if (ax_d != '0) begin
                        r_state <= S_LO;
                    end else if (last_axis) begin
                        r_state <= S_FINISH;
                    end
                end
                S_LO: begin
                    if (div_done) r_state <= S_HI;
                end
                S_HI: begin
                    if (div_done) r_state <= last_axis ? S_FINISH : S_AXIS;
                end
                S_FINISH: begin
                    r_state <= r_box.last_box ? S_EMIT : S_IDLE;
                end
                S_EMIT: begin
                    if (emit_go) r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // per-box slab work
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_box        <= i_in_data;
            r_box_ok     <= box_ok_in;
            r_axis       <= AXIS_X;
            r_intersects <= 1'b1;
            r_inside     <= 1'b1;
            r_enter      <= '0;
            r_leave      <= FRAC_ONE;
            r_axis_sel   <= AXIS_NONE;
            r_sign_sel   <= 1'b0;
        end
        if ((r_state == S_AXIS) && r_box_ok) begin
            r_inside <= r_inside && ax_in;
            if (ax_d == '0) begin
                // parallel axis: only the outside test applies
                if (!ax_in) r_intersects <= 1'b0;
                r_axis <= r_axis + 1'b1;
            end
        end
        if ((r_state == S_LO) && div_done) begin
            r_near <= div_quot;
        end
        if ((r_state == S_HI) && div_done) begin
            if (near_v > r_enter) begin
                r_enter    <= near_v;
                r_axis_sel <= r_axis;
                r_sign_sel <= sg_v;
            end
            if (far_v < r_leave) r_leave <= far_v;
            r_axis <= r_axis + 1'b1;
        end
    end

    // trace state and best hit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_box_cnt          <= '0;
            r_best_frac        <= MFRAC_W'(ONE_Q16);
            r_best_box         <= '0;
            r_best_axis        <= AXIS_NONE;
            r_best_sign        <= 1'b0;
            r_best_start_solid <= 1'b0;
            r_best_all_solid   <= 1'b0;
            r_any_found        <= 1'b0;
        end else if (r_state == S_FINISH) begin
            r_box_cnt <= (r_box_cnt == BOX_IDX_W'(MAX_BOXES - 1)) ? '0 :
                         r_box_cnt + 1'b1;
            if (hit) begin
                r_best_frac        <= r_enter[MFRAC_W-1:0];
                r_best_box         <= r_box_cnt;
                r_best_axis        <= r_axis_sel;
                r_best_sign        <= r_sign_sel;
                r_best_start_solid <= r_inside;
                r_best_all_solid   <= r_inside && (r_leave >= FRAC_ONE);
                r_any_found        <= 1'b1;
            end
        end else if (emit_go) begin
            r_box_cnt          <= '0;
            r_best_frac        <= r_max_frac;
            r_best_box         <= '0;
            r_best_axis        <= AXIS_NONE;
            r_best_sign        <= 1'b0;
            r_best_start_solid <= 1'b0;
            r_best_all_solid   <= 1'b0;
            r_any_found        <= 1'b0;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit_go) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit_go) begin
            if (r_any_found) begin
                r_out.found           <= 1'b1;
                r_out.hit_box         <= HIT_BOX_W'(r_best_box);
                r_out.hit_fraction    <= r_best_frac;
                r_out.normal_axis     <= r_best_axis;
                r_out.normal_positive <= r_best_sign;
                r_out.start_solid     <= r_best_start_solid;
                r_out.all_solid       <= r_best_all_solid;
            end else begin
                r_out.found           <= 1'b0;
                r_out.hit_box         <= '0;
                r_out.hit_fraction    <= '0;
                r_out.normal_axis     <= AXIS_NONE;
                r_out.normal_positive <= 1'b0;
                r_out.start_solid     <= 1'b0;
                r_out.all_solid       <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

>>> rtl/core/sbnh_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbnh_checker
// Port-level checks of the nearest-hit unit, bound to the top level.
// ----------------------------------------------------------------------------
module sbnh_checker import sbnh_pkg::*; (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_cfg_we,
    input logic [CFG_IDX_W-1:0]  i_cfg_index,
    input logic [CFG_DATA_W-1:0] i_cfg_data,
    input logic                  i_in_valid,
    input logic                  o_in_ready,
    input t_box                  i_in_data,
    input logic                  o_out_valid,
    input logic                  i_out_ready,
    input t_hit                  o_out_data
);

    logic cfg_seen;
    assign cfg_seen = i_cfg_we && (i_cfg_index <= CFG_MAX_FRAC) && (i_cfg_data == i_cfg_data);

    // a waiting result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("result beat changed while stalled");

    // a box not marked last keeps the unit busy for at least the following cycle
    a_busy_after_box: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && !i_in_data.last_box |=> !o_in_ready)
        else $error("ready right after a box was taken");

    a_miss_format: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.found |->
            (o_out_data.normal_axis == AXIS_NONE) && (o_out_data.hit_box == '0) &&
            (o_out_data.hit_fraction == '0) && !o_out_data.normal_positive &&
            !o_out_data.start_solid && !o_out_data.all_solid)
        else $error("miss result carries hit fields");

    // hit fraction is below one (ONE_Q16), all-solid needs start-solid,
    // a +1 normal needs an entry axis
    a_hit_format: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.found |->
            (o_out_data.hit_fraction < MFRAC_W'(ONE_Q16)) &&
            (!o_out_data.all_solid || o_out_data.start_solid) &&
            (!o_out_data.normal_positive || (o_out_data.normal_axis != AXIS_NONE)))
        else $error("inconsistent hit result");

    a_cfg_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cfg_seen |-> o_in_ready)
        else $error("configuration written while a box is in flight");

endmodule

bind segment_box_nearest_hit_unit sbnh_checker u_sbnh_checker (.*);
